>>> design/msc_pkg.sv
// msc_pkg: shared types and fixed widths for the sigma clipping outlier mask
// used by the top level, the shared multiplier and nothing else

package msc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int STORE_W   = SAMPLE_W + 1;
  localparam int LIMIT_W   = 8;
  localparam int SUM_W     = 22;
  localparam int SQ_W      = 37;
  localparam int MUL_A_W   = 28;
  localparam int MUL_B_W   = 24;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int WORK_W    = 64;
  localparam int SPLIT_W   = 24;
  localparam int DIFF_W    = 24;
  localparam int DEV_W     = 23;
  localparam int LN_W      = 22;

  localparam logic [LIMIT_W-1:0] SD_LIMIT_RESET = 8'd48;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       included;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic keep;
    logic spread_undefined;
    logic last_out;
  } out_t;

endpackage

>>> design/msc_ram.sv
// msc_ram: generic single write port, single read port ram
// registered read data, no reset on contents; no package dependency

module msc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/msc_mul.sv
// msc_mul: shared unsigned multiplier with registered product
// depends on msc_pkg for operand widths

module msc_mul (
  input  logic                         clk,
  input  logic [msc_pkg::MUL_A_W-1:0]  a,
  input  logic [msc_pkg::MUL_B_W-1:0]  b,
  output logic [msc_pkg::MUL_P_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= msc_pkg::MUL_P_W'(a) * msc_pkg::MUL_P_W'(b);
  end

endmodule

>>> design/masked_sigma_clip_outlier_mask_core.sv
// masked_sigma_clip_outlier_mask_core: sigma clipping keep mask over one column
// input: one sample transaction per cycle while collecting; the x*x product is registered
// in the shared multiplier before it is summed. after the last sample: setup states S_E0 to
// S_E7 on the shared multiplier, then states S_P0 to S_P4 (ram read plus three multiplies) per result
// rst (synchronous) empties the column and sets sd_limit to 3.0; the store needs no clear
// depends on msc_pkg, msc_ram and msc_mul

module masked_sigma_clip_outlier_mask_core #(
  parameter int COLUMN_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [msc_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  msc_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output msc_pkg::out_t               out_data
);

  localparam int IW = $clog2(COLUMN_DEPTH);
  localparam int CW = $clog2(COLUMN_DEPTH + 1);

  localparam logic [3:0] S_IN  = 4'd0;
  localparam logic [3:0] S_E0  = 4'd1;
  localparam logic [3:0] S_E1  = 4'd2;
  localparam logic [3:0] S_E2  = 4'd3;
  localparam logic [3:0] S_E3  = 4'd4;
  localparam logic [3:0] S_E4  = 4'd5;
  localparam logic [3:0] S_E5  = 4'd6;
  localparam logic [3:0] S_E6  = 4'd7;
  localparam logic [3:0] S_E7  = 4'd8;
  localparam logic [3:0] S_P0  = 4'd9;
  localparam logic [3:0] S_P1  = 4'd10;
  localparam logic [3:0] S_P2  = 4'd11;
  localparam logic [3:0] S_P3  = 4'd12;
  localparam logic [3:0] S_P4  = 4'd13;
  localparam logic [3:0] S_OUT = 4'd14;

  logic [3:0]                         state;
  logic [msc_pkg::LIMIT_W-1:0]        sd_limit;
  logic [CW-1:0]                      cnt;
  logic [CW-1:0]                      inc_cnt;
  logic signed [msc_pkg::SUM_W-1:0]   sum;
  logic [msc_pkg::SQ_W-1:0]           sq;
  logic                               sq_pend;
  logic [msc_pkg::WORK_W-1:0]         spread;
  logic [msc_pkg::WORK_W-1:0]         rhs;
  logic [msc_pkg::LN_W-1:0]           ln;
  logic [msc_pkg::DEV_W-1:0]          dev;
  logic                               vneg;
  logic                               vinc;
  logic [IW-1:0]                      idx;
  msc_pkg::out_t                      result;

  logic                               in_fire;
  logic                               out_fire;
  logic                               room;
  logic                               undef;
  logic                               at_end;
  logic [msc_pkg::SAMPLE_W:0]         abs_x;
  logic [msc_pkg::SAMPLE_W:0]         abs_v;
  logic [msc_pkg::SUM_W-1:0]          abs_sum;
  logic [msc_pkg::STORE_W-1:0]        rdata;
  logic [IW-1:0]                      raddr;
  logic signed [msc_pkg::DIFF_W-1:0]  nv;
  logic signed [msc_pkg::DIFF_W-1:0]  diff;
  logic [msc_pkg::MUL_A_W-1:0]        mul_a;
  logic [msc_pkg::MUL_B_W-1:0]        mul_b;
  logic [msc_pkg::MUL_P_W-1:0]        mul_p;
  logic [msc_pkg::WORK_W-1:0]         lhs;

  assign in_ready  = (state == S_IN);
  assign out_valid = (state == S_OUT);
  assign out_data  = result;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign room      = (cnt < CW'(COLUMN_DEPTH));
  assign undef     = (inc_cnt < CW'(2));
  assign at_end    = ((CW'(idx) + CW'(1)) == cnt);

  assign abs_x   = in_data.sample[msc_pkg::SAMPLE_W-1]
                   ? (msc_pkg::SAMPLE_W+1)'(-{in_data.sample[msc_pkg::SAMPLE_W-1],
                                              in_data.sample})
                   : {1'b0, in_data.sample};
  assign abs_v   = rdata[msc_pkg::STORE_W-1]
                   ? (msc_pkg::SAMPLE_W+1)'(-{rdata[msc_pkg::STORE_W-1],
                                              rdata[msc_pkg::STORE_W-1:1]})
                   : {1'b0, rdata[msc_pkg::STORE_W-1:1]};
  assign abs_sum = sum[msc_pkg::SUM_W-1] ? msc_pkg::SUM_W'(-sum) : msc_pkg::SUM_W'(sum);

  // signed n*v rebuilt from the magnitude product, then distance from the sum
  assign nv   = vneg ? -$signed({2'b00, mul_p[msc_pkg::LN_W-1:0]})
                     : $signed({2'b00, mul_p[msc_pkg::LN_W-1:0]});
  assign diff = nv - {{(msc_pkg::DIFF_W-msc_pkg::SUM_W){sum[msc_pkg::SUM_W-1]}}, sum};
  assign lhs  = msc_pkg::WORK_W'({mul_p, 8'h00});

  assign raddr = (state == S_OUT) ? IW'(idx + IW'(1)) : idx;

  msc_ram #(
    .WIDTH (msc_pkg::STORE_W),
    .DEPTH (COLUMN_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && room),
    .waddr (cnt[IW-1:0]),
    .wdata ({in_data.sample, in_data.included}),
    .raddr (raddr),
    .rdata (rdata)
  );

  msc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // operand select for the shared multiplier; the product comes back registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IN: begin
        mul_a = msc_pkg::MUL_A_W'(abs_x);
        mul_b = msc_pkg::MUL_B_W'(abs_x);
      end
      S_E0: begin
        mul_a = msc_pkg::MUL_A_W'(abs_sum);
        mul_b = msc_pkg::MUL_B_W'(abs_sum);
      end
      S_E1: begin
        mul_a = msc_pkg::MUL_A_W'(inc_cnt);
        mul_b = sq[msc_pkg::SPLIT_W-1:0];
      end
      S_E2: begin
        mul_a = msc_pkg::MUL_A_W'(inc_cnt);
        mul_b = msc_pkg::MUL_B_W'(sq[msc_pkg::SQ_W-1:msc_pkg::SPLIT_W]);
      end
      S_E3: begin
        mul_a = msc_pkg::MUL_A_W'(sd_limit);
        mul_b = msc_pkg::MUL_B_W'(sd_limit);
      end
      S_E4: begin
        mul_a = msc_pkg::MUL_A_W'(mul_p[2*msc_pkg::LIMIT_W-1:0]);
        mul_b = msc_pkg::MUL_B_W'(inc_cnt);
      end
      S_E5: begin
        mul_a = msc_pkg::MUL_A_W'(mul_p[msc_pkg::LN_W-1:0]);
        mul_b = spread[msc_pkg::SPLIT_W-1:0];
      end
      S_E6: begin
        mul_a = msc_pkg::MUL_A_W'(ln);
        mul_b = msc_pkg::MUL_B_W'(spread[42:msc_pkg::SPLIT_W]);
      end
      S_P0: begin
        mul_a = msc_pkg::MUL_A_W'(inc_cnt);
        mul_b = msc_pkg::MUL_B_W'(abs_v);
      end
      S_P2: begin
        mul_a = msc_pkg::MUL_A_W'(inc_cnt - CW'(1));
        mul_b = msc_pkg::MUL_B_W'(dev);
      end
      S_P3: begin
        mul_a = mul_p[msc_pkg::MUL_A_W-1:0];
        mul_b = msc_pkg::MUL_B_W'(dev);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IN;
      sd_limit <= msc_pkg::SD_LIMIT_RESET;
      cnt      <= '0;
      inc_cnt  <= '0;
      sum      <= '0;
      sq       <= '0;
      sq_pend  <= 1'b0;
      idx      <= '0;
    end else begin
      if (cfg_wen) begin
        sd_limit <= cfg_wdata;
      end
      if (sq_pend) begin
        sq <= sq + msc_pkg::SQ_W'(mul_p[2*msc_pkg::SAMPLE_W-1:0]);
      end
      sq_pend <= in_fire && room && in_data.included;
      unique case (state)
        S_IN: begin
          if (in_fire) begin
            if (room) begin
              cnt <= cnt + CW'(1);
              if (in_data.included) begin
                inc_cnt <= inc_cnt + CW'(1);
                sum     <= sum + {{(msc_pkg::SUM_W-msc_pkg::SAMPLE_W)
                                   {in_data.sample[msc_pkg::SAMPLE_W-1]}}, in_data.sample};
              end
            end
            if (in_data.last) begin
              idx   <= '0;
              state <= S_E0;
            end
          end
        end
        S_E0: state <= S_E1;
        S_E1: state <= S_E2;
        S_E2: state <= S_E3;
        S_E3: state <= S_E4;
        S_E4: state <= S_E5;
        S_E5: state <= S_E6;
        S_E6: state <= S_E7;
        S_E7: state <= S_P0;
        S_P0: state <= S_P1;
        S_P1: state <= S_P2;
        S_P2: state <= S_P3;
        S_P3: state <= S_P4;
        S_P4: state <= S_OUT;
        S_OUT: begin
          if (out_fire) begin
            if (at_end) begin
              cnt     <= '0;
              inc_cnt <= '0;
              sum     <= '0;
              sq      <= '0;
              idx     <= '0;
              state   <= S_IN;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_P0;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  // datapath registers along the sequence
  always_ff @(posedge clk) begin
    unique case (state)
      S_E1: spread <= msc_pkg::WORK_W'(mul_p);
      // n*Q low part minus S^2, high part added next; wraps are harmless mod 2^64
      S_E2: spread <= msc_pkg::WORK_W'(mul_p) - spread;
      S_E3: spread <= spread + (msc_pkg::WORK_W'(mul_p) << msc_pkg::SPLIT_W);
      S_E5: ln <= mul_p[msc_pkg::LN_W-1:0];
      S_E6: rhs <= msc_pkg::WORK_W'(mul_p);
      S_E7: rhs <= rhs + (msc_pkg::WORK_W'(mul_p) << msc_pkg::SPLIT_W);
      S_P0: begin
        vneg <= rdata[msc_pkg::STORE_W-1];
        vinc <= rdata[0];
      end
      S_P1: dev <= diff[msc_pkg::DIFF_W-1] ? msc_pkg::DEV_W'(-diff)
                                           : diff[msc_pkg::DEV_W-1:0];
      S_P4: begin
        result.keep             <= vinc && (undef || (lhs < rhs));
        result.spread_undefined <= undef;
        result.last_out         <= at_end;
      end
      default: begin
      end
    endcase
  end

endmodule
